[hdl/easing_curve_interpolator_macros.svh]
// ----------------------------------------------------------------------------
// Easing curve interpolator assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_INTERPOLATOR_MACROS_SVH
`define EASING_CURVE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define ECI_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eci check failed");

// next-cycle implication
`define ECI_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eci check failed");

`endif

[hdl/eci_pkg.sv]
// ----------------------------------------------------------------------------
// Easing curve interpolator package
// Widths, curve codes, quarter-wave sine and 2^x tables, root step.
// ----------------------------------------------------------------------------
`default_nettype none

package eci_pkg;

	localparam int PROGRESS_FRAC_BITS = 15;
	localparam int VALUE_BITS         = 16;
	localparam int SINE_IDX_BITS      = 8;
	localparam int SINE_TABLE_DEPTH   = 1 << SINE_IDX_BITS;
	localparam int SINE_FRAC_BITS     = 16 - SINE_IDX_BITS;
	localparam int EXP_TABLE_BITS     = 8;
	localparam int EXP_TABLE_DEPTH    = 1 << EXP_TABLE_BITS;
	localparam int EXP_FRAC_BITS      = 16 - EXP_TABLE_BITS;

	localparam longint PI_HALF_Q30 = 64'sd1686629713;
	localparam longint LN2_Q30     = 64'sd744261118;
	localparam longint Q30_ONE     = 64'sd1073741824;

	localparam int ONE_Q16     = 65536;
	localparam int BACK_S_Q16  = 111515;
	localparam int BACK_S1_Q16 = 177051;
	// floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^23
	localparam int DIV3_MUL   = 5592406;
	localparam int DIV3_SHIFT = 24;

	typedef enum logic [3:0] {
		ACT_LINEAR  = 4'd0,
		ACT_QUAD    = 4'd1,
		ACT_CUBIC   = 4'd2,
		ACT_QUART   = 4'd3,
		ACT_QUINT   = 4'd4,
		ACT_SINE    = 4'd5,
		ACT_CIRC    = 4'd6,
		ACT_EXPO    = 4'd7,
		ACT_ELASTIC = 4'd8,
		ACT_BACK    = 4'd9,
		ACT_BOUNCE  = 4'd10
	} action_t;

	typedef logic [17:0] tab_word_t;
	typedef tab_word_t sine_tab_t [0:SINE_TABLE_DEPTH];
	typedef tab_word_t exp_tab_t [0:EXP_TABLE_DEPTH];

	typedef struct packed {
		logic [32:0] rem;
		logic [16:0] res;
	} root_t;

	// Taylor series of sin, terms divided by (2n)(2n+1) for n = 1..11
	function automatic longint sine_entry(longint i);
		longint x;
		longint term;
		longint sum;
		longint r;
		x = PI_HALF_Q30 * i / SINE_TABLE_DEPTH;
		term = x;
		sum = x;
		term = -(term * x / Q30_ONE) / 6;   sum += term;
		term = -(term * x / Q30_ONE) / 20;  sum += term;
		term = -(term * x / Q30_ONE) / 42;  sum += term;
		term = -(term * x / Q30_ONE) / 72;  sum += term;
		term = -(term * x / Q30_ONE) / 110; sum += term;
		term = -(term * x / Q30_ONE) / 156; sum += term;
		term = -(term * x / Q30_ONE) / 210; sum += term;
		term = -(term * x / Q30_ONE) / 272; sum += term;
		term = -(term * x / Q30_ONE) / 342; sum += term;
		term = -(term * x / Q30_ONE) / 420; sum += term;
		term = -(term * x / Q30_ONE) / 506; sum += term;
		if (sum < 0)
			sum = 0;
		r = (sum + 8192) / 16384;
		return (r > ONE_Q16) ? longint'(ONE_Q16) : r;
	endfunction

	// Taylor series of e^z, terms divided by n for n = 1..12
	function automatic longint exp_entry(longint k);
		longint z;
		longint term;
		longint sum;
		z = (LN2_Q30 * k) >>> EXP_TABLE_BITS;
		term = Q30_ONE;
		sum = Q30_ONE;
		term = term * z / Q30_ONE;      sum += term;
		term = term * z / Q30_ONE / 2;  sum += term;
		term = term * z / Q30_ONE / 3;  sum += term;
		term = term * z / Q30_ONE / 4;  sum += term;
		term = term * z / Q30_ONE / 5;  sum += term;
		term = term * z / Q30_ONE / 6;  sum += term;
		term = term * z / Q30_ONE / 7;  sum += term;
		term = term * z / Q30_ONE / 8;  sum += term;
		term = term * z / Q30_ONE / 9;  sum += term;
		term = term * z / Q30_ONE / 10; sum += term;
		term = term * z / Q30_ONE / 11; sum += term;
		term = term * z / Q30_ONE / 12; sum += term;
		return (sum + 8192) / 16384;
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
			tab[i] = tab_word_t'(sine_entry(longint'(i)));
		return tab;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
			tab[i] = tab_word_t'(exp_entry(longint'(i)));
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();
	localparam exp_tab_t  EXP_TAB  = build_exp_tab();

	// one bit of the restoring root: keep the bit when the remainder covers it
	function automatic root_t root_step(root_t s, int b);
		root_t       o;
		logic [34:0] trial;
		o = s;
		trial = (35'(s.res) << (b + 1)) + (35'(1) << (2 * b));
		if ({2'b00, s.rem} >= trial) begin
			o.rem = s.rem - trial[32:0];
			o.res = s.res | (17'(1) << b);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

[hdl/eci_req_if.sv]
// ----------------------------------------------------------------------------
// Easing curve request channel
// Valid/ready beat carrying curve code, endpoints and progress.
// ----------------------------------------------------------------------------
`default_nettype none

interface eci_req_if;
	logic                                     valid;
	logic                                     ready;
	logic [3:0]                               action;
	logic signed [eci_pkg::VALUE_BITS-1:0]    start_value;
	logic signed [eci_pkg::VALUE_BITS-1:0]    end_value;
	logic [eci_pkg::PROGRESS_FRAC_BITS:0]     progress;

	modport source (output valid, action, start_value, end_value, progress, input ready);
	modport sink (input valid, action, start_value, end_value, progress, output ready);
endinterface

`default_nettype wire

[hdl/eci_rsp_if.sv]
// ----------------------------------------------------------------------------
// Easing curve response channel
// Valid/ready beat carrying the interpolated value and clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface eci_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [eci_pkg::VALUE_BITS-1:0] value;
	logic                                  saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink (input valid, value, saturated, output ready);
endinterface

`default_nettype wire

[hdl/eci_root.sv]
// ----------------------------------------------------------------------------
// Easing curve square root
// Seventeen-bit floor root of a 33-bit value over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_root (
	input  logic        clk,
	input  logic        adv,
	input  logic [32:0] x,
	output logic [16:0] root
);

	eci_pkg::root_t st3_d;
	eci_pkg::root_t st4_d;
	eci_pkg::root_t st5_d;
	eci_pkg::root_t st_s3;
	eci_pkg::root_t st_s4;
	logic [16:0]    root_s5;

	always_comb begin
		st3_d = '{rem: x, res: 17'd0};
		for (int b = 16; b >= 11; b--)
			st3_d = eci_pkg::root_step(st3_d, b);
	end

	always_comb begin
		st4_d = st_s3;
		for (int b = 10; b >= 5; b--)
			st4_d = eci_pkg::root_step(st4_d, b);
	end

	always_comb begin
		st5_d = st_s4;
		for (int b = 4; b >= 0; b--)
			st5_d = eci_pkg::root_step(st5_d, b);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s3   <= st3_d;
			st_s4   <= st4_d;
			root_s5 <= st5_d.res;
		end
	end

	assign root = root_s5;

endmodule

`default_nettype wire

[hdl/easing_curve_interpolator.sv]
// An accepted request beat passes stage registers s1 to s7 before its response beat.
// Throughput: one beat per cycle while the output is not held; the seven-stage pipeline, multipliers
// and the three-stage square root all take a new beat every cycle.
// A response held by the sink stalls every stage at once; nothing is lost.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// Easing curve interpolator
// Ease-in factor for eleven curves, then start + span * factor, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "easing_curve_interpolator_macros.svh"

module easing_curve_interpolator (
	input  logic  clk,
	input  logic  arst_n,
	eci_req_if.sink   req,
	eci_rsp_if.source rsp
);

	localparam int VB   = eci_pkg::VALUE_BITS;
	localparam int PFB  = eci_pkg::PROGRESS_FRAC_BITS;
	localparam int SIB  = eci_pkg::SINE_IDX_BITS;
	localparam int SFB  = eci_pkg::SINE_FRAC_BITS;
	localparam int EFB  = eci_pkg::EXP_FRAC_BITS;
	localparam int ETB  = eci_pkg::EXP_TABLE_BITS;
	localparam int T_SHL = (PFB <= 16) ? 16 - PFB : 0;
	localparam int T_SHR = (PFB > 16) ? PFB - 16 : 0;
	localparam logic [PFB:0] P_ONE = {1'b1, {PFB{1'b0}}};
	localparam logic [16:0] ONE17 = 17'(eci_pkg::ONE_Q16);
	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1
	logic [PFB:0]           p_cl;
	logic [16:0]            t_in;
	logic signed [VB:0]     span_in;
	logic [3:0]             act_s1;
	logic [16:0]            t_s1, w_s1;
	logic                   tz_s1;
	logic signed [VB-1:0]   st_s1;
	logic signed [VB:0]     span_s1;

	// stage 2
	logic [33:0]            t2p;
	logic [SIB:0]           si, sbi;
	logic [20:0]            tenw, ew;
	logic [ETB-1:0]         ek;
	logic [21:0]            a40;
	logic [45:0]            q3p;
	logic [35:0]            bkp;
	logic [19:0]            v11;
	logic signed [22:0]     w22, bu_w;
	logic [15:0]            bd_d;
	logic [16:0]            t2_s2, t_s2;
	logic [17:0]            sa_s2, sb_s2, ea_s2, eb_s2;
	logic [SFB-1:0]         sfr_s2;
	logic [EFB-1:0]         elo_s2;
	logic [3:0]             exn_s2;
	logic [19:0]            eq_s2;
	logic signed [18:0]     bk_s2;
	logic [19:0]            bu_s2;
	logic [15:0]            bd_s2;
	logic [3:0]             act_s2;
	logic                   tz_s2;
	logic signed [VB-1:0]   st_s2;
	logic signed [VB:0]     span_s2;

	// stage 3
	logic [33:0]            t3p;
	logic [17:0]            sdif, edif, sv1, em;
	logic [33:0]            spr;
	logic [25:0]            epr;
	logic [16:0]            dm;
	logic [20:0]            phw;
	logic [16:0]            arg2;
	logic [SIB:0]           si2, sbi2;
	logic signed [36:0]     fbp;
	logic [39:0]            bup;
	logic [16:0]            t3_s3, t2_s3, t_s3, fs_s3;
	logic [17:0]            ex_s3, a2_s3, b2_s3;
	logic [SFB-1:0]         fr2_s3;
	logic                   ng_s3;
	logic signed [18:0]     fb_s3, fo_s3;
	logic [3:0]             act_s3;
	logic                   tz_s3;
	logic signed [VB-1:0]   st_s3;
	logic signed [VB:0]     span_s3;

	// stage 4
	logic [33:0]            t4p;
	logic [17:0]            sdif2, sv2;
	logic [33:0]            spr2;
	logic [16:0]            t4_s4, t3_s4, t2_s4, t_s4, fs_s4;
	logic [17:0]            ex_s4;
	logic signed [18:0]     sn_s4, fb_s4, fo_s4;
	logic [3:0]             act_s4;
	logic                   tz_s4;
	logic signed [VB-1:0]   st_s4;
	logic signed [VB:0]     span_s4;

	// stage 5
	logic [33:0]            t5p;
	logic signed [18:0]     exs;
	logic signed [37:0]     fep;
	logic [16:0]            root_s5;
	logic [16:0]            t5_s5, t4_s5, t3_s5, t2_s5, t_s5, fs_s5;
	logic [17:0]            ex_s5;
	logic signed [18:0]     fe_s5, fb_s5, fo_s5;
	logic [3:0]             act_s5;
	logic                   tz_s5;
	logic signed [VB-1:0]   st_s5;
	logic signed [VB:0]     span_s5;

	// stage 6
	logic signed [18:0]     f_sel;
	logic signed [VB+19:0]  prod_s6;
	logic signed [VB-1:0]   st_s6;

	// stage 7
	logic signed [VB+19:0]  rnd;
	logic signed [VB+4:0]   sum;
	logic signed [VB-1:0]   val_s7;
	logic                   sat_s7;

	// whole pipe advances unless the output beat is held
	assign adv       = !v_s7 || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = v_s7;
	assign rsp.value = val_s7;
	assign rsp.saturated = sat_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ---------------- stage 1: clamp progress, bring t to Q16
	always_comb begin
		p_cl = (req.progress > P_ONE) ? P_ONE : req.progress;
		t_in = 17'(({16'd0, p_cl} << T_SHL) >> T_SHR);
		span_in = {req.end_value[VB-1], req.end_value}
			- {req.start_value[VB-1], req.start_value};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= req.action;
			t_s1    <= t_in;
			w_s1    <= ONE17 - t_in;
			tz_s1   <= (req.progress == '0);
			st_s1   <= req.start_value;
			span_s1 <= span_in;
		end
	end

	// ---------------- stage 2: t^2, table fetches, reciprocal divide, back slope, bounce segment
	always_comb begin
		t2p  = 34'(t_s1) * 34'(t_s1);
		si   = w_s1[16:SFB];
		sbi  = (si == (SIB+1)'(eci_pkg::SINE_TABLE_DEPTH)) ? si : si + 1'b1;
		tenw = 21'(w_s1) * 21'd10;
		ew   = 21'd0 - tenw;
		ek   = ew[15:EFB];
		a40  = 22'(w_s1) * 22'd40;
		// floor(-40w/3) = -floor((40w+2)/3)
		q3p  = 46'(a40 + 22'd2) * 46'(eci_pkg::DIV3_MUL);
		bkp  = 36'(t_s1) * 36'(eci_pkg::BACK_S1_Q16);
		v11  = 20'(w_s1) * 20'd11;
		w22  = $signed(23'(w_s1) * 23'd22);
		if (v11 < 20'd262144) begin
			bu_w = w22;
			bd_d = 16'd0;
		end else if (v11 < 20'd524288) begin
			bu_w = w22 - 23'sd786432;
			bd_d = 16'd49152;
		end else if (v11 < 20'd655360) begin
			bu_w = w22 - 23'sd1179648;
			bd_d = 16'd61440;
		end else begin
			bu_w = w22 - 23'sd1376256;
			bd_d = 16'd64512;
		end
		if (bu_w < 0)
			bu_w = -bu_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s2   <= t2p[32:16];
			sa_s2   <= eci_pkg::SINE_TAB[si];
			sb_s2   <= eci_pkg::SINE_TAB[sbi];
			sfr_s2  <= w_s1[SFB-1:0];
			ea_s2   <= eci_pkg::EXP_TAB[{1'b0, ek}];
			eb_s2   <= eci_pkg::EXP_TAB[(ETB+1)'(ek) + 1'b1];
			elo_s2  <= ew[EFB-1:0];
			exn_s2  <= 4'(5'd0 - ew[20:16]);
			eq_s2   <= q3p[eci_pkg::DIV3_SHIFT+19:eci_pkg::DIV3_SHIFT];
			bk_s2   <= $signed({1'b0, bkp[33:16]}) - 19'(eci_pkg::BACK_S_Q16);
			bu_s2   <= bu_w[19:0];
			bd_s2   <= bd_d;
			t_s2    <= t_s1;
			act_s2  <= act_s1;
			tz_s2   <= tz_s1;
			st_s2   <= st_s1;
			span_s2 <= span_s1;
		end
	end

	// ---------------- stage 3: t^3, sine and 2^x interpolation, back, bounce
	always_comb begin
		t3p  = 34'(t2_s2) * 34'(t_s2);
		sdif = sb_s2 - sa_s2;
		spr  = 34'(sdif) * 34'({sfr_s2, {SIB{1'b0}}});
		sv1  = sa_s2 + 18'(spr >> 16);
		edif = eb_s2 - ea_s2;
		epr  = 26'(edif) * 26'(elo_s2);
		em   = ea_s2 + 18'(epr >> EFB);
		dm   = ONE17 - t2_s2;
		// elastic phase in quarter turns, wrapped to one full turn
		phw  = 21'd0 - (21'(eq_s2) + 21'(eci_pkg::ONE_Q16));
		arg2 = phw[16] ? ONE17 - {1'b0, phw[15:0]} : {1'b0, phw[15:0]};
		si2  = arg2[16:SFB];
		sbi2 = (si2 == (SIB+1)'(eci_pkg::SINE_TABLE_DEPTH)) ? si2 : si2 + 1'b1;
		fbp  = 37'($signed({1'b0, t2_s2})) * 37'(bk_s2);
		bup  = 40'(bu_s2) * 40'(bu_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t3_s3   <= t3p[32:16];
			fs_s3   <= ONE17 - sv1[16:0];
			ex_s3   <= em >> exn_s2;
			a2_s3   <= eci_pkg::SINE_TAB[si2];
			b2_s3   <= eci_pkg::SINE_TAB[sbi2];
			fr2_s3  <= arg2[SFB-1:0];
			ng_s3   <= phw[17];
			fb_s3   <= 19'(fbp >>> 16);
			fo_s3   <= $signed(19'(eci_pkg::ONE_Q16) - 19'(bup[39:22]) - 19'(bd_s2));
			t2_s3   <= t2_s2;
			t_s3    <= t_s2;
			act_s3  <= act_s2;
			tz_s3   <= tz_s2;
			st_s3   <= st_s2;
			span_s3 <= span_s2;
		end
	end

	eci_root u_root (
		.clk  (clk),
		.adv  (adv),
		.x    ({dm, 16'd0}),
		.root (root_s5)
	);

	// ---------------- stage 4: t^4, elastic sine
	always_comb begin
		t4p   = 34'(t3_s3) * 34'(t_s3);
		sdif2 = b2_s3 - a2_s3;
		spr2  = 34'(sdif2) * 34'({fr2_s3, {SIB{1'b0}}});
		sv2   = a2_s3 + 18'(spr2 >> 16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t4_s4   <= t4p[32:16];
			sn_s4   <= ng_s3 ? -$signed({1'b0, sv2}) : $signed({1'b0, sv2});
			ex_s4   <= ex_s3;
			fs_s4   <= fs_s3;
			fb_s4   <= fb_s3;
			fo_s4   <= fo_s3;
			t3_s4   <= t3_s3;
			t2_s4   <= t2_s3;
			t_s4    <= t_s3;
			act_s4  <= act_s3;
			tz_s4   <= tz_s3;
			st_s4   <= st_s3;
			span_s4 <= span_s3;
		end
	end

	// ---------------- stage 5: t^5, elastic decay times sine
	always_comb begin
		t5p = 34'(t4_s4) * 34'(t_s4);
		exs = $signed({1'b0, ex_s4});
		fep = 38'(exs) * 38'(sn_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t5_s5   <= t5p[32:16];
			fe_s5   <= 19'(38'sd0 - (fep >>> 16));
			ex_s5   <= ex_s4;
			fs_s5   <= fs_s4;
			fb_s5   <= fb_s4;
			fo_s5   <= fo_s4;
			t4_s5   <= t4_s4;
			t3_s5   <= t3_s4;
			t2_s5   <= t2_s4;
			t_s5    <= t_s4;
			act_s5  <= act_s4;
			tz_s5   <= tz_s4;
			st_s5   <= st_s4;
			span_s5 <= span_s4;
		end
	end

	// ---------------- stage 6: pick the curve, scale the span
	always_comb begin
		case (eci_pkg::action_t'(act_s5))
			eci_pkg::ACT_QUAD:    f_sel = $signed({2'b00, t2_s5});
			eci_pkg::ACT_CUBIC:   f_sel = $signed({2'b00, t3_s5});
			eci_pkg::ACT_QUART:   f_sel = $signed({2'b00, t4_s5});
			eci_pkg::ACT_QUINT:   f_sel = $signed({2'b00, t5_s5});
			eci_pkg::ACT_SINE:    f_sel = $signed({2'b00, fs_s5});
			eci_pkg::ACT_CIRC:    f_sel = $signed({2'b00, ONE17 - root_s5});
			eci_pkg::ACT_EXPO:    f_sel = tz_s5 ? 19'sd0 : $signed({1'b0, ex_s5});
			eci_pkg::ACT_ELASTIC: f_sel = fe_s5;
			eci_pkg::ACT_BACK:    f_sel = fb_s5;
			eci_pkg::ACT_BOUNCE:  f_sel = fo_s5;
			default:              f_sel = $signed({2'b00, t_s5});
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s6 <= (VB+20)'(span_s5) * (VB+20)'(f_sel);
			st_s6   <= st_s5;
		end
	end

	// ---------------- stage 7: round half up, add start, clip
	always_comb begin
		rnd = (prod_s6 + (VB+20)'(32768)) >>> 16;
		sum = (VB+5)'(st_s6) + (VB+5)'(rnd);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sum > (VB+5)'(VMAX)) begin
				val_s7 <= VMAX;
				sat_s7 <= 1'b1;
			end else if (sum < (VB+5)'(VMIN)) begin
				val_s7 <= VMIN;
				sat_s7 <= 1'b1;
			end else begin
				val_s7 <= sum[VB-1:0];
				sat_s7 <= 1'b0;
			end
		end
	end

	`ECI_CHECK_NEXT(a_stall_freezes_pipe, !adv, v_s1 == $past(v_s1) && v_s6 == $past(v_s6))
	`ECI_CHECK_NEXT(a_accept_enters_pipe, req.valid && req.ready, v_s1)
	`ECI_CHECK_NOW(a_clip_at_rail, v_s7 && sat_s7, val_s7 == VMAX || val_s7 == VMIN)

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Easing curve interpolator bench
// Drives curve requests with random gaps, predicts each eased value in fixed
// point and compares every response beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	typedef struct {
		logic signed [eci_pkg::VALUE_BITS-1:0] value;
		logic                                  saturated;
	} eased_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	eci_req_if req ();
	eci_rsp_if rsp ();

	easing_curve_interpolator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #5 clk = ~clk;

	eased_t eased_q[$];
	int     mismatches = 0;
	bit     calm = 1'b0;

	longint sine_lut[0:eci_pkg::SINE_TABLE_DEPTH];
	longint exp_lut[0:eci_pkg::EXP_TABLE_DEPTH];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return floor_shr(a * b, 16);
	endfunction

	function automatic longint sine_val(longint x);
		longint x30;
		longint term;
		longint sum;
		longint r;
		x30 = eci_pkg::PI_HALF_Q30 * x / eci_pkg::SINE_TABLE_DEPTH;
		term = x30;
		sum = x30;
		for (longint n = 1; n <= 11; n++) begin
			term = -(term * x30 / eci_pkg::Q30_ONE) / ((2 * n) * (2 * n + 1));
			sum += term;
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 8192) / 16384;
		return (r > eci_pkg::ONE_Q16) ? eci_pkg::ONE_Q16 : r;
	endfunction

	function automatic longint pow2_val(longint k);
		longint z;
		longint term;
		longint sum;
		z = (eci_pkg::LN2_Q30 * k) >>> eci_pkg::EXP_TABLE_BITS;
		term = eci_pkg::Q30_ONE;
		sum = eci_pkg::Q30_ONE;
		for (longint n = 1; n <= 12; n++) begin
			term = term * z / eci_pkg::Q30_ONE / n;
			sum += term;
		end
		return (sum + 8192) / 16384;
	endfunction

	function automatic longint quarter_sine(longint q);
		longint pos;
		longint i;
		longint fr;
		if (q < 0)
			q = 0;
		if (q > eci_pkg::ONE_Q16)
			q = eci_pkg::ONE_Q16;
		pos = q * eci_pkg::SINE_TABLE_DEPTH;
		i = pos >> 16;
		fr = pos & 16'hFFFF;
		if (i >= eci_pkg::SINE_TABLE_DEPTH)
			return sine_lut[eci_pkg::SINE_TABLE_DEPTH];
		return sine_lut[i] + floor_shr((sine_lut[i+1] - sine_lut[i]) * fr, 16);
	endfunction

	function automatic longint turn_sine(longint ph);
		longint p;
		longint r;
		p = ph % (4 * eci_pkg::ONE_Q16);
		if (p < 0)
			p += 4 * eci_pkg::ONE_Q16;
		r = p & 16'hFFFF;
		case (p >> 16)
			0: return quarter_sine(r);
			1: return quarter_sine(eci_pkg::ONE_Q16 - r);
			2: return -quarter_sine(r);
			default: return -quarter_sine(eci_pkg::ONE_Q16 - r);
		endcase
	endfunction

	function automatic longint pow2_neg(longint e);
		longint ip;
		longint fr;
		longint n;
		longint k;
		longint lo;
		longint m;
		if (e > 0)
			e = 0;
		ip = floor_shr(e, 16);
		fr = e - ip * eci_pkg::ONE_Q16;
		n = -ip;
		k = fr >> eci_pkg::EXP_FRAC_BITS;
		lo = fr & ((1 << eci_pkg::EXP_FRAC_BITS) - 1);
		m = exp_lut[k] + (((exp_lut[k+1] - exp_lut[k]) * lo) >>> eci_pkg::EXP_FRAC_BITS);
		if (n >= 40)
			return 0;
		return m >>> n;
	endfunction

	function automatic longint int_root(longint x);
		longint res;
		longint cand;
		res = 0;
		for (int b = 16; b >= 0; b--) begin
			cand = res | (longint'(1) << b);
			if (cand * cand <= x)
				res = cand;
		end
		return res;
	endfunction

	function automatic longint bounce_curve(longint t);
		longint v;
		longint u;
		longint d;
		v = eci_pkg::ONE_Q16 - t;
		if (11 * v < 4 * eci_pkg::ONE_Q16) begin
			u = 22 * v; d = 0;
		end else if (11 * v < 8 * eci_pkg::ONE_Q16) begin
			u = 22 * v - 12 * eci_pkg::ONE_Q16; d = 49152;
		end else if (11 * v < 10 * eci_pkg::ONE_Q16) begin
			u = 22 * v - 18 * eci_pkg::ONE_Q16; d = 61440;
		end else begin
			u = 22 * v - 21 * eci_pkg::ONE_Q16; d = 64512;
		end
		if (u < 0)
			u = -u;
		return eci_pkg::ONE_Q16 - (((u * u) >> 22) + d);
	endfunction

	function automatic longint curve_factor(logic [3:0] act, longint t, bit tzero);
		longint t2;
		longint v;
		longint num;
		longint q;
		t2 = qmul(t, t);
		case (act)
			eci_pkg::ACT_QUAD:   return t2;
			eci_pkg::ACT_CUBIC:  return qmul(t2, t);
			eci_pkg::ACT_QUART:  return qmul(qmul(t2, t), t);
			eci_pkg::ACT_QUINT:  return qmul(qmul(qmul(t2, t), t), t);
			eci_pkg::ACT_SINE:   return eci_pkg::ONE_Q16 - quarter_sine(eci_pkg::ONE_Q16 - t);
			eci_pkg::ACT_CIRC:   return eci_pkg::ONE_Q16 - int_root((eci_pkg::ONE_Q16 - t2) << 16);
			eci_pkg::ACT_EXPO:   return tzero ? 0 : pow2_neg(10 * (t - eci_pkg::ONE_Q16));
			eci_pkg::ACT_ELASTIC: begin
				v = t - eci_pkg::ONE_Q16;
				num = 40 * v;
				q = num / 3;
				if (num % 3 != 0 && num < 0)
					q -= 1;
				return -qmul(pow2_neg(10 * v), turn_sine(q - eci_pkg::ONE_Q16));
			end
			eci_pkg::ACT_BACK:
				return qmul(t2, ((eci_pkg::BACK_S1_Q16 * t) >>> 16) - eci_pkg::BACK_S_Q16);
			eci_pkg::ACT_BOUNCE: return bounce_curve(t);
			default:             return t;
		endcase
	endfunction

	function automatic eased_t interpolate(logic [3:0] act, logic signed [15:0] s,
			logic signed [15:0] e, logic [16:0] p);
		eased_t o;
		longint pc;
		longint f;
		longint r;
		pc = (p > 17'd32768) ? 32768 : longint'(p);
		f = curve_factor(act, pc << (16 - eci_pkg::PROGRESS_FRAC_BITS), p == 0);
		r = longint'(s) + floor_shr((longint'(e) - longint'(s)) * f + 32768, 16);
		o.saturated = 1'b0;
		if (r > 32767) begin
			r = 32767; o.saturated = 1'b1;
		end
		if (r < -32768) begin
			r = -32768; o.saturated = 1'b1;
		end
		o.value = r[15:0];
		return o;
	endfunction

	// hold the beat until accepted; drop valid only before an idle burst
	task automatic send_point(logic [3:0] act, logic [15:0] s, logic [15:0] e,
			logic [15:0] p);
		eased_t pred;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.start_value <= s;
		req.end_value <= e;
		req.progress <= p;
		do @(posedge clk); while (!req.ready);
		pred = interpolate(act, s, e, {1'b0, p});
		eased_q = {eased_q, pred};
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_progress();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(32760, 32768));
			2: return 16'($urandom_range(0, 8));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic test_directed();
		for (int a = 0; a <= 10; a++)
			send_point(4'(a), 16'h8000, 16'h7FFF, 16'(a * 3000));
		send_point(eci_pkg::ACT_EXPO, 16'h0100, 16'h7000, 16'd0);
		send_point(eci_pkg::ACT_LINEAR, 16'h8000, 16'h7FFF, 16'd32768);
		send_point(eci_pkg::ACT_QUAD, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_point(4'd11, 16'h0000, 16'h1000, 16'd16384);
		send_point(4'd15, 16'h1234, 16'hEDCB, 16'd20000);
		send_point(eci_pkg::ACT_BACK, 16'h7FFF, 16'h8000, 16'd8000);
		send_point(eci_pkg::ACT_BACK, 16'h8000, 16'h7FFF, 16'd8000);
		send_point(eci_pkg::ACT_ELASTIC, 16'h8000, 16'h7FFF, 16'd30000);
		send_point(eci_pkg::ACT_ELASTIC, 16'h7FFF, 16'h8000, 16'd31000);
		send_point(eci_pkg::ACT_BOUNCE, 16'h0000, 16'h7FFF, 16'd32768);
		send_point(eci_pkg::ACT_CIRC, 16'h0000, 16'h7FFF, 16'd1);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_point(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom),
				rand_progress());
	endtask

	task automatic test_streaming(int n);
		calm = 1'b1;
		test_random(n);
	endtask

	// response side: random stalls, compare each beat with oldest prediction
	initial begin
		eased_t want;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (eased_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: value %0d sat %0b", rsp.value, rsp.saturated);
				end else begin
					want = eased_q.pop_front();
					if (rsp.value !== want.value || rsp.saturated !== want.saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0b got %0d/%0b",
								want.value, want.saturated, rsp.value, rsp.saturated);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		for (int i = 0; i <= eci_pkg::SINE_TABLE_DEPTH; i++)
			sine_lut[i] = sine_val(i);
		for (int i = 0; i <= eci_pkg::EXP_TABLE_DEPTH; i++)
			exp_lut[i] = pow2_val(i);
		req.valid = 1'b0;
		req.action = '0;
		req.start_value = '0;
		req.end_value = '0;
		req.progress = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(1300);
		test_streaming(230);
		req.valid <= 1'b0;
		while (eased_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && eased_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
